### rtl/core/kmer_window_counter_macros.svh
// Assertion macros for the k-mer window counter
`ifndef KMER_WINDOW_COUNTER_MACROS_SVH
`define KMER_WINDOW_COUNTER_MACROS_SVH
// antecedent implies consequent in the same cycle
`define KWC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kwc check failed");
// antecedent implies consequent in the next cycle
`define KWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kwc check failed");
`endif

### rtl/core/kwc_pkg.sv
// ----------------------------------------------------------------------------
// kwc_pkg
// Shared types and constants of the k-mer window counter.
// ----------------------------------------------------------------------------
`default_nettype none
package kwc_pkg;
  localparam int unsigned KeyW = 64;
  localparam int unsigned CountW = 32;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7A;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [63:0] HashMul = 64'h9E3779B97F4A7C15;

  typedef struct packed {
    logic start;
    logic load_key;
    logic hash_lo;
    logic hash_hi;
    logic hash_fin;
    logic rd;
    logic probe_next;
    logic wr_new;
    logic wr_inc;
    logic out_load;
    logic out_full;
  } cmd_t;

  typedef struct packed {
    logic clearing_done;
    logic emit;
    logic hit_free;
    logic hit_match;
    logic probes_done;
    logic table_full;
  } stat_t;
endpackage
`default_nettype wire

### rtl/core/kwc_stream_if.sv
// ----------------------------------------------------------------------------
// kwc_stream_if
// Valid/ready channel carrying an input or result payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface kwc_in_if;
  logic valid;
  logic ready;
  logic [7:0] char_byte;
  logic seq_start;
  modport source (output valid, char_byte, seq_start, input ready);
  modport sink (input valid, char_byte, seq_start, output ready);
endinterface

interface kwc_out_if;
  logic valid;
  logic ready;
  logic [63:0] kmer_key;
  logic [31:0] kmer_count;
  logic table_full;
  modport source (output valid, kmer_key, kmer_count, table_full, input ready);
  modport sink (input valid, kmer_key, kmer_count, table_full, output ready);
endinterface
`default_nettype wire

### rtl/core/kwc_datapath.sv
// ----------------------------------------------------------------------------
// kwc_datapath
// Window, key packing, hashing, probe table and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module kwc_datapath
  import kwc_pkg::*;
#(
  parameter int unsigned MaxK = 8,
  parameter int unsigned Entries = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [3:0] kmer_length,
  input  wire logic [7:0] char_byte,
  input  wire logic seq_start,
  input  wire cmd_t cmd,
  output stat_t stat,
  output logic [KeyW-1:0] res_key,
  output logic [CountW-1:0] res_count,
  output logic res_full
);
  localparam int unsigned AW = $clog2(Entries);
  localparam int unsigned KW = $clog2(MaxK + 1);

  logic [7:0] window [MaxK];
  logic [KW-1:0] run;
  logic [KeyW-1:0] key;
  logic [31:0] pb, pc;
  logic [63:0] lo_full;
  logic [AW-1:0] slot;
  logic [AW:0] probes;
  logic [AW:0] used;
  logic [AW:0] clr;
  logic clear_done;
  logic valid_mem [Entries];
  logic [KeyW-1:0] mem_key [Entries];
  logic [CountW-1:0] mem_cnt [Entries];
  logic [KeyW-1:0] rd_key;
  logic [CountW-1:0] rd_cnt;
  logic rd_valid;
  logic [7:0] up;
  logic sep;
  logic [KW-1:0] k_eff;
  logic [KeyW-1:0] key_pack;
  logic [KeyW-1:0] hx;

  always_comb begin
    up = char_byte;
    if (char_byte >= ChLowA && char_byte <= ChLowZ) begin
      up = char_byte - (ChLowA - ChUpA);
    end
    sep = (up == ChSpace) || (up == ChCr) || (up == ChLf);
    if (kmer_length == 4'd0) begin
      k_eff = KW'(1);
    end else if (32'(kmer_length) > MaxK) begin
      k_eff = KW'(MaxK);
    end else begin
      k_eff = KW'(kmer_length);
    end
    key_pack = '0;
    for (int i = 0; i < MaxK; i++) begin
      if (i < int'(k_eff)) begin
        key_pack[i*8 +: 8] = window[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxK; i++) window[i] <= '0;
      run <= '0;
    end else if (cmd.start) begin
      for (int i = MaxK - 1; i > 0; i--) begin
        window[i] <= seq_start ? 8'd0 : window[i-1];
      end
      window[0] <= up;
      if (sep) begin
        run <= '0;
      end else if (seq_start) begin
        run <= KW'(1);
      end else if (32'(run) < MaxK) begin
        run <= run + KW'(1);
      end
    end
  end

  // hash: 64x64 low product as three 32x32 partial products
  always_ff @(posedge clk) begin
    if (cmd.load_key) key <= key_pack;
    if (cmd.hash_lo) lo_full <= 64'(key[31:0]) * 64'(HashMul[31:0]);
    if (cmd.hash_hi) begin
      pb <= 32'(key[31:0] * HashMul[63:32]);
      pc <= 32'(key[63:32] * HashMul[31:0]);
    end
  end

  always_comb begin
    hx = {lo_full[63:32] + pb + pc, lo_full[31:0]};
    hx = hx ^ (hx >> 29);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probes <= '0;
    end else if (cmd.hash_fin) begin
      slot <= hx[AW-1:0];
      probes <= '0;
    end else if (cmd.probe_next) begin
      slot <= slot + AW'(1);
      probes <= probes + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key <= mem_key[slot];
      rd_cnt <= mem_cnt[slot];
    end
    if (cmd.wr_new) begin
      mem_key[slot] <= key;
      mem_cnt[slot] <= CountW'(1);
    end else if (cmd.wr_inc && rd_cnt != '1) begin
      mem_cnt[slot] <= rd_cnt + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_valid <= valid_mem[slot];
    if (!clear_done) begin
      valid_mem[clr[AW-1:0]] <= 1'b0;
    end else if (cmd.wr_new) begin
      valid_mem[slot] <= 1'b1;
    end
  end

  assign clear_done = (clr == (AW+1)'(Entries));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      clr <= '0;
    end else begin
      if (!clear_done) clr <= clr + (AW+1)'(1);
      if (cmd.wr_new) used <= used + (AW+1)'(1);
    end
  end

  always_comb begin
    stat = '0;
    stat.clearing_done = clear_done;
    stat.emit = (run >= k_eff);
    stat.hit_free = !rd_valid;
    stat.hit_match = rd_valid && (rd_key == key);
    stat.probes_done = (probes == (AW+1)'(Entries - 1));
    stat.table_full = (used == (AW+1)'(Entries));
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_key <= key;
      res_full <= cmd.out_full;
      if (cmd.out_full) begin
        res_count <= '0;
      end else if (cmd.wr_new) begin
        res_count <= CountW'(1);
      end else if (rd_cnt != '1) begin
        res_count <= rd_cnt + CountW'(1);
      end else begin
        res_count <= rd_cnt;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/kwc_ctrl.sv
// ----------------------------------------------------------------------------
// kwc_ctrl
// Sequencer: window step, hash, probe, update, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module kwc_ctrl
  import kwc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire stat_t stat,
  output cmd_t cmd
);
`include "kmer_window_counter_macros.svh"
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY = 3'd1;
  localparam logic [2:0] S_HA = 3'd2;
  localparam logic [2:0] S_HB = 3'd3;
  localparam logic [2:0] S_RD = 3'd4;
  localparam logic [2:0] S_CMP = 3'd5;

  logic [2:0] state, state_next;
  logic out_busy;
  logic emit_cycle;

  assign in_ready = (state == S_IDLE) && stat.clearing_done && (!out_busy || out_ready);
  assign out_valid = out_busy;

  always_comb begin
    cmd = '0;
    state_next = state;
    emit_cycle = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start = 1'b1;
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        if (stat.emit) begin
          cmd.load_key = 1'b1;
          state_next = S_HA;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HA: begin
        cmd.hash_lo = 1'b1;
        cmd.hash_hi = 1'b1;
        state_next = S_HB;
      end
      S_HB: begin
        cmd.hash_fin = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.hit_free && !stat.table_full) begin
          cmd.wr_new = 1'b1;
          emit_cycle = 1'b1;
        end else if (stat.hit_match) begin
          cmd.wr_inc = 1'b1;
          emit_cycle = 1'b1;
        end else if (stat.probes_done) begin
          cmd.out_full = 1'b1;
          emit_cycle = 1'b1;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = S_RD;
        end
        if (emit_cycle) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_busy <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_busy <= 1'b1;
      else if (out_ready) out_busy <= 1'b0;
    end
  end

  `KWC_ASSERT_IMP(a_ready_idle, in_ready, state == S_IDLE)
  `KWC_ASSERT_NEXT(a_start_key, cmd.start, state == S_KEY)
  `KWC_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid)
  `KWC_ASSERT_IMP(a_one_write, cmd.wr_new, !cmd.wr_inc)
endmodule
`default_nettype wire

### rtl/core/kmer_window_counter.sv
// ----------------------------------------------------------------------------
// kmer_window_counter
// Sliding-window k-mer extraction with a hashed, saturating count table.
// Sequence: a character that forms no k-mer goes back to idle after the key
//   check; one that forms a k-mer is hashed, then read and compared per probe.
// Input is taken again only once the last character is through the probe
//   loop on the single-port table and the result register is free or being read.
// Reset: synchronous; clears window, run length and fill count, then holds
//   input off while a pass clears the valid marks of all TABLE_ENTRIES slots.
// ----------------------------------------------------------------------------
`default_nettype none
module kmer_window_counter
  import kwc_pkg::*;
#(
  parameter int unsigned MAX_KMER_LENGTH = 8,
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [3:0] cfg_wdata,
  kwc_in_if.sink in_ch,
  kwc_out_if.source out_ch
);
  logic [3:0] kmer_length;
  cmd_t cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) kmer_length <= 4'd4;
    else if (cfg_we) kmer_length <= cfg_wdata;
  end

  kwc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  kwc_datapath #(.MaxK(MAX_KMER_LENGTH), .Entries(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst),
    .kmer_length(kmer_length),
    .char_byte(in_ch.char_byte), .seq_start(in_ch.seq_start),
    .cmd(cmd), .stat(stat),
    .res_key(out_ch.kmer_key), .res_count(out_ch.kmer_count),
    .res_full(out_ch.table_full)
  );
endmodule
`default_nettype wire

### dv/kwc_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_tb_if
// The testbench drives and watches the counter through the channel
// interfaces kwc_in_if and kwc_out_if of the RTL interface file.
// ----------------------------------------------------------------------------

### dv/kwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_checker
// Watches the character and result channels, predicts each k-mer count
// with its own window and hash table, and compares in order.
// ----------------------------------------------------------------------------
module kwc_checker
  import kwc_pkg::*;
#(
  parameter int unsigned TBL = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [7:0] in_char,
  input  logic in_start,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [63:0] out_key,
  input  logic [31:0] out_count,
  input  logic out_full,
  output int   fail_count,
  output int   pending
);
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] count;
    logic        full;
  } kmer_res_t;

  kmer_res_t   count_q[$];
  logic [3:0]  klen;
  logic [7:0]  win [8];
  int unsigned clean_run;
  bit          tvalid [TBL];
  logic [63:0] tkey [TBL];
  logic [31:0] tcnt [TBL];

  function automatic int unsigned slot_of(logic [63:0] key);
    logic [63:0] h;
    h = key * HashMul;
    h = h ^ (h >> 29);
    return h % TBL;
  endfunction

  task automatic count_char(logic [7:0] c0, logic st);
    int unsigned k;
    int unsigned s;
    logic [7:0] c;
    logic [63:0] key;
    kmer_res_t r;
    bit done;
    k = (klen == 0) ? 1 : (klen > 8 ? 8 : klen);
    c = c0;
    key = '0;
    done = 0;
    if (st) begin
      foreach (win[i]) win[i] = '0;
      clean_run = 0;
    end
    if (c >= ChLowA && c <= ChLowZ) c = c - 8'h20;
    for (int i = 7; i > 0; i--) win[i] = win[i-1];
    win[0] = c;
    if (c == ChSpace || c == ChCr || c == ChLf) clean_run = 0;
    else if (clean_run < 8) clean_run++;
    if (clean_run < k) return;
    for (int i = k; i > 0; i--) key = (key << 8) | win[i-1];
    s = slot_of(key);
    r = '{key: key, count: '0, full: 1'b1};
    for (int p = 0; p < TBL && !done; p++) begin
      if (!tvalid[s]) begin
        tvalid[s] = 1;
        tkey[s] = key;
        tcnt[s] = 1;
        r = '{key: key, count: 1, full: 1'b0};
        done = 1;
      end else if (tkey[s] == key) begin
        if (tcnt[s] != '1) tcnt[s]++;
        r = '{key: key, count: tcnt[s], full: 1'b0};
        done = 1;
      end
      s = (s + 1) % TBL;
    end
    count_q.push_back(r);
  endtask

  always @(posedge clk) begin
    kmer_res_t e;
    int errs;
    errs = 0;
    if (rst) begin
      klen <= 4'd4;
      foreach (win[i]) win[i] = '0;
      clean_run = 0;
      foreach (tvalid[i]) tvalid[i] = 0;
      count_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) klen <= cfg_wdata;
      if (in_valid && in_ready) count_char(in_char, in_start);
      if (out_valid && out_ready) begin
        if (count_q.size() == 0) begin
          $error("unexpected result key=%h", out_key);
          errs++;
        end else begin
          e = count_q.pop_front();
          if (out_key !== e.key) begin
            $error("kmer_key exp %h got %h", e.key, out_key);
            errs++;
          end
          if (out_count !== e.count) begin
            $error("kmer_count exp %0d got %0d", e.count, out_count);
            errs++;
          end
          if (out_full !== e.full) begin
            $error("table_full exp %0d got %0d", e.full, out_full);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= count_q.size();
    end
  end
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives characters and k values into the k-mer counter with random gaps
// and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import kwc_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         send_idle;
  int         recv_idle;
  int         stall_cycles;
  logic [7:0] dna [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

  kwc_in_if  in_ch ();
  kwc_out_if out_ch ();

  kmer_window_counter DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  kwc_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_char(in_ch.char_byte), .in_start(in_ch.seq_start),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_key(out_ch.kmer_key), .out_count(out_ch.kmer_count),
    .out_full(out_ch.table_full),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c, logic st);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= c;
    in_ch.seq_start <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle_and_set(logic [3:0] k);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_ch.ready || out_ch.valid) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_str(string s, logic st);
    for (int i = 0; i < s.len(); i++) send_char(s[i], st && i == 0);
  endtask

  task automatic random_block(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        send_char(dna[$urandom_range(3)] | ($urandom_range(1) ? 8'h20 : 8'h00),
                  $urandom_range(29) == 0);
      else
        send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = '0;
    in_ch.seq_start = 1'b0;
    send_idle = 14;
    recv_idle = 54;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_str("acgtACGT", 1'b1);
    send_str("AC", 1'b1);
    send_str("GT AC\rGT\nACGTz", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    settle_and_set(4'd1);
    send_str("aZ", 1'b1);
    settle_and_set(4'd0);
    send_str("Tt", 1'b0);
    settle_and_set(4'd15);
    send_str("ACGTACGTA", 1'b1);
    settle_and_set(4'd8);
    random_block(150);
    settle_and_set(4'd2);
    random_block(150);
    send_idle = 54;
    recv_idle = 14;
    settle_and_set(4'd3);
    random_block(150);
    send_idle = 0;
    recv_idle = 0;
    settle_and_set(4'd5);
    send_str("ACGT", 1'b1);
    settle_and_set(4'd3);
    random_block(150);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/kwc_pkg.sv
rtl/core/kwc_stream_if.sv
rtl/core/kwc_datapath.sv
rtl/core/kwc_ctrl.sv
rtl/core/kmer_window_counter.sv
dv/kwc_tb_if.sv
dv/kwc_checker.sv
dv/tb_top.sv
